@@ rtl/fbd_pkg.sv @@
// Fieldbus deframer package: frame kind and status codes, start and end byte
// constants, the byte classifier and the structs passed between the front and back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbd_pkg;

  localparam logic [7:0] SD_SC  = 8'hE5;
  localparam logic [7:0] SD_SD1 = 8'h10;
  localparam logic [7:0] SD_SD2 = 8'h68;
  localparam logic [7:0] SD_SD3 = 8'hA2;
  localparam logic [7:0] SD_SD4 = 8'hDC;
  localparam logic [7:0] ED     = 8'h16;

  localparam logic [8:0] FIXED_LEN      = 9'd6;
  localparam logic [8:0] FIXED_DATA_LEN = 9'd14;
  localparam logic [8:0] TOKEN_LEN      = 9'd3;
  localparam logic [8:0] VAR_OVERHEAD   = 9'd6;
  localparam logic [8:0] DROP_LEN       = 9'd3;
  localparam logic [8:0] HDR_DEPTH      = 9'd6;

  typedef enum logic [2:0] {
    KIND_SHORT_ACK = 3'd0,
    KIND_FIXED     = 3'd1,
    KIND_VAR       = 3'd2,
    KIND_FDATA     = 3'd3,
    KIND_TOKEN     = 3'd4,
    KIND_UNKNOWN   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_LEN_DIFF  = 3'd2,
    ST_SD2_BAD   = 3'd3,
    ST_NO_ED     = 3'd4,
    ST_CHECKSUM  = 3'd5
  } status_t;

  typedef struct packed {
    kind_t start_kind;
    logic  imm;      // frame ends on this byte when it starts a frame
    logic  is_ed;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
  } fbd_item_t;

  typedef struct packed {
    kind_t      kind;
    status_t    status;
    logic [8:0] length;
    logic       last;
  } fbd_result_t;

  function automatic byte_class_t fbd_classify(logic [7:0] b);
    byte_class_t c;
    case (b)
      SD_SC:   c.start_kind = KIND_SHORT_ACK;
      SD_SD1:  c.start_kind = KIND_FIXED;
      SD_SD2:  c.start_kind = KIND_VAR;
      SD_SD3:  c.start_kind = KIND_FDATA;
      SD_SD4:  c.start_kind = KIND_TOKEN;
      default: c.start_kind = KIND_UNKNOWN;
    endcase
    c.imm   = (c.start_kind == KIND_SHORT_ACK) || (c.start_kind == KIND_UNKNOWN);
    c.is_ed = (b == ED);
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/fbd_front.sv @@
// Deframer front end: classifies each received byte and holds it in a
// two-entry queue for the parser. Depends on fbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbd_front
  import fbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_data_byte,
  output logic            in_stall,
  output logic            q_valid,
  output fbd_item_t       q_item,
  input  wire logic       q_pop
);

  fbd_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data: in_data_byte, cls: fbd_classify(in_data_byte)};
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/fbd_engine.sv @@
// Deframer back end: frame parser, header and replay stores, checksum
// tracking and the result register. Depends on fbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbd_engine
  import fbd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire fbd_item_t q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output fbd_result_t out_res
);

  logic [8:0]  cnt_r, cnt_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  hdr_r [6];
  logic [7:0]  rep_r [3];
  logic [1:0]  rep_cnt_r, rep_cnt_nxt;
  logic        out_v_r;
  fbd_result_t out_res_r;

  logic        replaying, can_out, go, emit, clear, rep_load;
  logic [1:0]  rep_idx;
  logic [7:0]  rep_byte, b, len_eff;
  byte_class_t cls, cls_h3, cls_r1, cls_r2;
  logic [8:0]  n, total, pos_p2, first;
  logic        more;
  fbd_result_t res;

  assign replaying = (rep_cnt_r != 2'd0);
  assign rep_idx   = 2'd3 - rep_cnt_r;
  assign can_out   = !out_v_r || !out_stall;
  assign go        = can_out && (replaying || q_valid);
  assign q_pop     = go && !replaying;

  always_comb begin
    case (rep_idx)
      2'd0:    rep_byte = rep_r[0];
      2'd1:    rep_byte = rep_r[1];
      default: rep_byte = rep_r[2];
    endcase
  end

  assign b      = replaying ? rep_byte : q_item.data;
  assign cls    = replaying ? fbd_classify(rep_byte) : q_item.cls;
  assign cls_h3 = fbd_classify(hdr_r[3]);
  assign cls_r1 = fbd_classify(rep_r[1]);
  assign cls_r2 = fbd_classify(rep_r[2]);

  assign n       = cnt_r + 9'd1;
  assign pos_p2  = cnt_r + 9'd2;
  assign len_eff = (kind_r == KIND_VAR && n == 9'd2) ? b : len_r;
  assign first   = (kind_r == KIND_VAR) ? 9'd4 : 9'd1;

  always_comb begin
    case (kind_r)
      KIND_FIXED: total = FIXED_LEN;
      KIND_VAR:   total = {1'b0, len_eff} + VAR_OVERHEAD;
      KIND_FDATA: total = FIXED_DATA_LEN;
      KIND_TOKEN: total = TOKEN_LEN;
      default:    total = 9'd1;
    endcase
  end

  // one received or replayed byte per cycle while the output register can take a result
  always_comb begin
    cnt_nxt    = n;
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    rep_load   = 1'b0;
    emit       = 1'b0;
    clear      = 1'b0;
    res.kind   = kind_r;
    res.status = ST_OK;
    res.length = total;
    res.last   = !more;
    if (cnt_r == 9'd0) begin
      sum_nxt = 8'd0;
      len_nxt = 8'd0;
      if (cls.imm) begin
        emit       = 1'b1;
        clear      = 1'b1;
        res.kind   = cls.start_kind;
        res.status = (cls.start_kind == KIND_UNKNOWN) ? ST_BAD_START : ST_OK;
        res.length = 9'd1;
      end else begin
        kind_nxt = cls.start_kind;
      end
    end else if (kind_r == KIND_TOKEN) begin
      if (n >= TOKEN_LEN) begin
        emit       = 1'b1;
        clear      = 1'b1;
        res.length = TOKEN_LEN;
      end
    end else if (kind_r == KIND_VAR && n == 9'd3 && hdr_r[1] != b) begin
      emit       = 1'b1;
      clear      = 1'b1;
      res.status = ST_LEN_DIFF;
      res.length = DROP_LEN;
    end else if (kind_r == KIND_VAR && n == 9'd6 && hdr_r[3] != SD_SD2) begin
      emit       = 1'b1;
      clear      = 1'b1;
      rep_load   = 1'b1;
      res.status = ST_SD2_BAD;
      res.length = DROP_LEN;
    end else begin
      len_nxt = len_eff;
      if (cnt_r >= first && pos_p2 < total) begin
        sum_nxt = sum_r + b;
      end else if (pos_p2 == total) begin
        sum_nxt = sum_r - b;
      end
      if (n >= total) begin
        emit       = 1'b1;
        clear      = 1'b1;
        res.status = !cls.is_ed ? ST_NO_ED : (sum_nxt != 8'd0 ? ST_CHECKSUM : ST_OK);
      end
    end
    if (clear) begin
      cnt_nxt  = 9'd0;
      kind_nxt = KIND_SHORT_ACK;
      len_nxt  = 8'd0;
      sum_nxt  = 8'd0;
    end
  end

  // last-result flag: look ahead at what the replayed bytes will produce
  always_comb begin
    if (replaying) begin
      case (rep_idx)
        2'd0:    more = cls_r1.imm;
        2'd1:    more = cls_r2.imm;
        default: more = 1'b0;
      endcase
    end else if (rep_load) begin
      more = cls_h3.imm || (cls_h3.start_kind == KIND_TOKEN);
    end else begin
      more = 1'b0;
    end
  end

  always_comb begin
    if (go && rep_load) begin
      rep_cnt_nxt = 2'd3;
    end else if (go && replaying) begin
      rep_cnt_nxt = rep_cnt_r - 2'd1;
    end else begin
      rep_cnt_nxt = rep_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 9'd0;
      kind_r    <= KIND_SHORT_ACK;
      len_r     <= 8'd0;
      sum_r     <= 8'd0;
      rep_cnt_r <= 2'd0;
      out_v_r   <= 1'b0;
    end else begin
      rep_cnt_r <= rep_cnt_nxt;
      if (go) begin
        cnt_r   <= cnt_nxt;
        kind_r  <= kind_nxt;
        len_r   <= len_nxt;
        sum_r   <= sum_nxt;
        out_v_r <= emit;
      end else if (can_out) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && cnt_r < HDR_DEPTH) begin
      hdr_r[cnt_r[2:0]] <= b;
    end
    if (go && rep_load) begin
      rep_r[0] <= hdr_r[3];
      rep_r[1] <= hdr_r[4];
      rep_r[2] <= b;
    end
    if (go && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

  a_replay_short: assert property (@(posedge clk) disable iff (!rst_n)
    replaying |-> cnt_r < 9'd3)
    else $error("replay ran past three bytes");

  a_open_frame_kind: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 9'd0 |-> (kind_r == KIND_FIXED || kind_r == KIND_VAR ||
                       kind_r == KIND_FDATA || kind_r == KIND_TOKEN))
    else $error("open frame with a kind that ends at once");

  a_var_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 9'd0 && kind_r == KIND_VAR) |-> cnt_r < ({1'b0, len_r} + VAR_OVERHEAD))
    else $error("variable frame overran its length");

  a_replay_cause: assert property (@(posedge clk) disable iff (!rst_n)
    rep_cnt_r == 2'd3 |-> (out_v_r && out_res_r.status == ST_SD2_BAD))
    else $error("replay started without a second start error");

endmodule

`default_nettype wire

@@ rtl/fieldbus_frame_deframer_unit.sv @@
// Fieldbus frame deframer, top level.
// Takes one received byte per request and reports one result request per
// recognized or rejected frame: kind, status, byte count and a last flag
// that marks the final result caused by an input byte.
// Both channels use valid/stall; a request moves at an edge where valid is
// high and stall is low.
// A result caused by an accepted byte passes the queue and then the output
// register. Throughput is one byte per cycle while the output is not stalled,
// set by the single-byte parse step of the back end. A variable frame whose
// repeated start byte is wrong re-parses three header bytes, one per cycle
// while the output is not stalled, so that byte produces up to four results.
// A two-entry queue sits between the classifying front end and the parser;
// a stalled result holds in the output register, the parser waits, the
// queue fills and in_stall rises.
// Reset (synchronous, active low) drops any partial frame and empties the
// queue and the output register; nothing else needs clearing.
`timescale 1ns / 1ps
`default_nettype none

module fieldbus_frame_deframer_unit
  import fbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_frame_kind,
  output logic [2:0]      out_status,
  output logic [8:0]      out_frame_length,
  output logic            out_is_last
);

  logic        q_valid;
  logic        q_pop;
  fbd_item_t   q_item;
  fbd_result_t res;

  fbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  fbd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_frame_kind   = res.kind;
  assign out_status       = res.status;
  assign out_frame_length = res.length;
  assign out_is_last      = res.last;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for fieldbus_frame_deframer_unit: line bytes in, frame reports out.
// A byte-level deframer model predicts every report. Random gaps and stalls apply on both channels.
// Depends on fbd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module testbench;
  import fbd_pkg::*;

  localparam logic [8:0] VAR_SUM_FIRST = 9'd4;

  typedef enum {
    FLAW_NONE, FLAW_NO_ED, FLAW_SUM, FLAW_ED_AND_SUM, FLAW_LEN_PAIR, FLAW_SD2
  } frame_flaw_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_frame_kind;
  logic [2:0] out_status;
  logic [8:0] out_frame_length;
  logic       out_is_last;

  fieldbus_frame_deframer_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_frame_kind(out_frame_kind), .out_status(out_status),
    .out_frame_length(out_frame_length), .out_is_last(out_is_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0]  line_bytes[$];
  fbd_result_t expected_reports[$];
  fbd_result_t byte_reports[$];
  int          failures = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  // deframer state
  logic [8:0] frame_pos = '0;
  kind_t      frame_kind_q = KIND_SHORT_ACK;
  logic [7:0] frame_len_byte = '0;
  logic [7:0] frame_sum = '0;
  logic [7:0] header_bytes [0:5];
  bit         resync_due = 1'b0;

  function automatic int unsigned wait_draw(input bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic report(input kind_t k, input status_t s, input logic [8:0] len);
    fbd_result_t r;
    r.kind = k;
    r.status = s;
    r.length = len;
    r.last = 1'b0;
    byte_reports.push_back(r);
  endtask

  task automatic drop_frame();
    frame_pos = '0;
    frame_kind_q = KIND_SHORT_ACK;
    frame_len_byte = '0;
    frame_sum = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [8:0] pos, n, total, first, idx;
    kind_t      k;
    status_t    st;
    pos = frame_pos;
    n = pos + 9'd1;
    if (pos < HDR_DEPTH) header_bytes[pos[2:0]] = b;
    frame_pos = n;
    if (n == 9'd1) begin
      frame_sum = '0;
      frame_len_byte = '0;
      case (b)
        SD_SC: begin
          report(KIND_SHORT_ACK, ST_OK, 9'd1);
          drop_frame();
        end
        SD_SD1: frame_kind_q = KIND_FIXED;
        SD_SD2: frame_kind_q = KIND_VAR;
        SD_SD3: frame_kind_q = KIND_FDATA;
        SD_SD4: frame_kind_q = KIND_TOKEN;
        default: begin
          report(KIND_UNKNOWN, ST_BAD_START, 9'd1);
          drop_frame();
        end
      endcase
      return;
    end
    k = frame_kind_q;
    if (k == KIND_TOKEN) begin
      if (n >= TOKEN_LEN) begin
        report(KIND_TOKEN, ST_OK, TOKEN_LEN);
        drop_frame();
      end
      return;
    end
    if (k == KIND_VAR) begin
      if (n == 9'd2) frame_len_byte = b;
      if (n == 9'd3 && header_bytes[1] != header_bytes[2]) begin
        report(KIND_VAR, ST_LEN_DIFF, DROP_LEN);
        drop_frame();
        return;
      end
      if (n == 9'd6 && header_bytes[3] != SD_SD2) begin
        report(KIND_VAR, ST_SD2_BAD, DROP_LEN);
        drop_frame();
        resync_due = 1'b1;
        return;
      end
    end
    case (k)
      KIND_FIXED: total = FIXED_LEN;
      KIND_VAR:   total = {1'b0, frame_len_byte} + VAR_OVERHEAD;
      KIND_FDATA: total = FIXED_DATA_LEN;
      default:    total = 9'd1;
    endcase
    first = (k == KIND_VAR) ? VAR_SUM_FIRST : 9'd1;
    idx = n - 9'd1;
    if (idx >= first && idx + 9'd2 < total) frame_sum = frame_sum + b;
    else if (idx + 9'd2 == total) frame_sum = frame_sum - b;
    if (n >= total) begin
      if (b != ED) st = ST_NO_ED;
      else if (frame_sum != 8'h00) st = ST_CHECKSUM;
      else st = ST_OK;
      report(k, st, total);
      drop_frame();
    end
  endtask

  // one accepted line byte; a bad repeated start re-parses header bytes 3..5
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0]  replay [0:2];
    fbd_result_t r;
    byte_reports.delete();
    resync_due = 1'b0;
    parse_byte(b);
    if (resync_due) begin
      resync_due = 1'b0;
      replay[0] = header_bytes[3];
      replay[1] = header_bytes[4];
      replay[2] = header_bytes[5];
      for (int j = 0; j < 3; j++) parse_byte(replay[j]);
    end
    for (int j = 0; j < byte_reports.size(); j++) begin
      r = byte_reports[j];
      r.last = (j == byte_reports.size() - 1);
      expected_reports.push_back(r);
    end
  endtask

  function automatic bit is_start(input logic [7:0] b);
    return b == SD_SC || b == SD_SD1 || b == SD_SD2 || b == SD_SD3 || b == SD_SD4;
  endfunction

  function automatic logic [7:0] replay_pick();
    case ($urandom_range(0, 5))
      0: return SD_SC;
      1: return SD_SD4;
      2: return SD_SD1;
      3: return SD_SD2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_frame(input kind_t k, input frame_flaw_t flaw, input int unsigned le);
    logic [7:0]  b, cs;
    int unsigned n;
    cs = 8'h00;
    case (k)
      KIND_SHORT_ACK: line_bytes.push_back(SD_SC);
      KIND_UNKNOWN: begin
        b = 8'($urandom_range(0, 255));
        while (is_start(b)) b = 8'($urandom_range(0, 255));
        line_bytes.push_back(b);
      end
      KIND_TOKEN: begin
        line_bytes.push_back(SD_SD4);
        line_bytes.push_back(8'($urandom_range(0, 255)));
        line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        if (k == KIND_VAR) begin
          n = le;
          line_bytes.push_back(SD_SD2);
          line_bytes.push_back(le[7:0]);
          if (flaw == FLAW_LEN_PAIR) begin
            line_bytes.push_back(le[7:0] ^ 8'($urandom_range(1, 255)));
            return;
          end
          line_bytes.push_back(le[7:0]);
          if (flaw == FLAW_SD2) begin
            b = replay_pick();
            while (b == SD_SD2) b = replay_pick();
            line_bytes.push_back(b);
            line_bytes.push_back(replay_pick());
            line_bytes.push_back(replay_pick());
            return;
          end
          line_bytes.push_back(SD_SD2);
        end else begin
          n = (k == KIND_FIXED) ? 3 : 11;
          line_bytes.push_back(k == KIND_FIXED ? SD_SD1 : SD_SD3);
        end
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          cs = cs + b;
          line_bytes.push_back(b);
        end
        if (flaw == FLAW_SUM || flaw == FLAW_ED_AND_SUM) cs = cs ^ 8'($urandom_range(1, 255));
        line_bytes.push_back(cs);
        if (flaw == FLAW_NO_ED || flaw == FLAW_ED_AND_SUM) begin
          b = 8'($urandom_range(0, 255));
          if (b == ED) b = ~ED;
          line_bytes.push_back(b);
        end else begin
          line_bytes.push_back(ED);
        end
      end
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) deframe_byte(in_data_byte);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (line_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_data_byte <= line_bytes.pop_front();
          if ($urandom_range(0, 23) == 0) tx_calm = !tx_calm;
          gap_left = wait_draw(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    fbd_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result: kind %0d status %0d length %0d",
                 out_frame_kind, out_status, out_frame_length);
          failures++;
        end else begin
          want = expected_reports.pop_front();
          if (out_frame_kind !== want.kind) begin
            $error("frame_kind: expected %0d, got %0d", want.kind, out_frame_kind);
            failures++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            failures++;
          end
          if (out_frame_length !== want.length) begin
            $error("frame_length: expected %0d, got %0d", want.length, out_frame_length);
            failures++;
          end
          if (out_is_last !== want.last) begin
            $error("is_last: expected %0d, got %0d", want.last, out_is_last);
            failures++;
          end
        end
        if ($urandom_range(0, 23) == 0) rx_calm = !rx_calm;
        hold_left = wait_draw(rx_calm);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned le;
    frame_flaw_t flaw;
    kind_t       k;

    // directed: every kind, every status, replay cases
    add_frame(KIND_SHORT_ACK, FLAW_NONE, 0);
    line_bytes.push_back(8'h00);
    line_bytes.push_back(8'hFF);
    add_frame(KIND_TOKEN, FLAW_NONE, 0);
    add_frame(KIND_FIXED, FLAW_NONE, 0);
    add_frame(KIND_FIXED, FLAW_NO_ED, 0);
    add_frame(KIND_FIXED, FLAW_SUM, 0);
    add_frame(KIND_FIXED, FLAW_ED_AND_SUM, 0);
    add_frame(KIND_FDATA, FLAW_NONE, 0);
    add_frame(KIND_FDATA, FLAW_SUM, 0);
    add_frame(KIND_FDATA, FLAW_ED_AND_SUM, 0);
    add_frame(KIND_VAR, FLAW_NONE, 0);
    add_frame(KIND_VAR, FLAW_NONE, 1);
    add_frame(KIND_VAR, FLAW_SUM, 4);
    add_frame(KIND_VAR, FLAW_NO_ED, 3);
    add_frame(KIND_VAR, FLAW_LEN_PAIR, 7);
    // bad repeated start, replay gives two acks and an unknown start
    line_bytes.push_back(SD_SD2);
    line_bytes.push_back(8'd5);
    line_bytes.push_back(8'd5);
    line_bytes.push_back(SD_SC);
    line_bytes.push_back(SD_SC);
    line_bytes.push_back(8'h00);
    // replay completes a token
    line_bytes.push_back(SD_SD2);
    line_bytes.push_back(8'd9);
    line_bytes.push_back(8'd9);
    line_bytes.push_back(SD_SD4);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(8'h00);
    // good repeated start, no replay: a variable frame without its end byte, then two unknown starts
    line_bytes.push_back(SD_SD2);
    line_bytes.push_back(8'd3);
    line_bytes.push_back(8'd3);
    line_bytes.push_back(SD_SD2);
    line_bytes.push_back(8'd2);
    line_bytes.push_back(8'd2);
    line_bytes.push_back(SD_SD2);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(8'h01);
    line_bytes.push_back(8'h00);
    line_bytes.push_back(ED);

    // random: mostly well-formed frames, some flawed, some noise
    while (line_bytes.size() < 220) begin
      case ($urandom_range(0, 9))
        0: k = KIND_SHORT_ACK;
        1: k = KIND_TOKEN;
        2, 3: k = KIND_FIXED;
        4: k = KIND_FDATA;
        5: k = KIND_UNKNOWN;
        default: k = KIND_VAR;
      endcase
      case ($urandom_range(0, 19))
        15: flaw = FLAW_NO_ED;
        16: flaw = FLAW_SUM;
        17: flaw = FLAW_ED_AND_SUM;
        18: flaw = FLAW_LEN_PAIR;
        19: flaw = FLAW_SD2;
        default: flaw = FLAW_NONE;
      endcase
      if (k != KIND_VAR && (flaw == FLAW_LEN_PAIR || flaw == FLAW_SD2)) flaw = FLAW_NONE;
      le = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      if ($urandom_range(0, 24) == 0) line_bytes.push_back(8'($urandom_range(0, 255)));
      else add_frame(k, flaw, le);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (line_bytes.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fbd_pkg.sv
rtl/fbd_front.sv
rtl/fbd_engine.sv
rtl/fieldbus_frame_deframer_unit.sv
tb/testbench.sv
